// File: rtl/dda_line_pixel_stepper_top_macros.svh
// ----------------------------------------------------------------------------
// dda line pixel stepper assertion macros
// concurrent checks clocked on clk_i, held off while rst_ni is low
// ----------------------------------------------------------------------------
`ifndef DDA_LINE_PIXEL_STEPPER_TOP_MACROS_SVH
`define DDA_LINE_PIXEL_STEPPER_TOP_MACROS_SVH

// consequent must hold in the same cycle as the antecedent
`define DDALS_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// consequent must hold in the cycle after the antecedent
`define DDALS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/ddals_pkg.sv
// ----------------------------------------------------------------------------
// ddals_pkg
// shared widths, codes and transfer structs of the dda line pixel stepper
// ----------------------------------------------------------------------------
package ddals_pkg;

  localparam int COORD_BITS  = 12;
  localparam int FRAC_BITS   = 16;
  localparam int OUT_BITS    = COORD_BITS + 1;
  localparam int ACC_BITS    = OUT_BITS + FRAC_BITS;
  localparam int QUOT_BITS   = FRAC_BITS + 1;
  localparam int SLOPE_BITS  = FRAC_BITS + 2;
  localparam int CNT_BITS    = $clog2(FRAC_BITS + 1);
  localparam int QUEUE_DEPTH = 4;
  localparam int PTR_BITS    = $clog2(QUEUE_DEPTH);

  // gradient of exactly one, used for a single-point line
  localparam logic signed [SLOPE_BITS-1:0] SLOPE_ONE =
    {{(SLOPE_BITS-FRAC_BITS-1){1'b0}}, 1'b1, {FRAC_BITS{1'b0}}};

  typedef enum logic {
    OP_LOAD = 1'b0,
    OP_STEP = 1'b1
  } op_e;

  // classified item as it sits in the queue
  typedef struct packed {
    op_e                          op;
    logic                         steep;
    logic signed [COORD_BITS-1:0] mj0;
    logic signed [COORD_BITS-1:0] mj1;
    logic signed [COORD_BITS-1:0] mn0;
    logic        [COORD_BITS-1:0] dmaj;
    logic        [COORD_BITS-1:0] dmin_mag;
    logic                         dmin_neg;
    logic        [15:0]           color;
  } entry_t;

  typedef struct packed {
    logic                  start;
    logic [COORD_BITS-1:0] dividend;
    logic [COORD_BITS-1:0] divisor;
    logic                  neg;
  } div_req_t;

  typedef struct packed {
    logic                         done;
    logic signed [SLOPE_BITS-1:0] quotient;
  } div_rsp_t;

endpackage

// File: rtl/dda_line_pixel_stepper_top.sv
// ----------------------------------------------------------------------------
// dda_line_pixel_stepper_top
// fixed-point dda line stepper: loads a line, then gives one column per step
// ----------------------------------------------------------------------------
// usage
//   input channel: push_i with full_o; a transfer happens when push_i is high
//   and full_o is low. operation_i low loads a line (two endpoints and a
//   colour) and gives no result; operation_i high asks for the next column.
//   result channel: empty_o with pop_i; the oldest result sits on the result
//   ports while empty_o is low and leaves on a transfer with pop_i high.
//   order: a step item passes through the queue and then the result register
//   before its column shows. a load with a non-zero major span occupies the
//   back end for launch, the 17 quotient bits (one per divider iteration) and
//   writeback; a single-point line loads without the divider.
//   throughput: one column per cycle while the receiver keeps popping and
//   no load divides; a four-entry queue keeps items arriving during a divide.
//   a step with no line in progress is taken and dropped; the final column
//   carries last_column_o and ends the line.
//   reset: rst_ni clears the queue, the line state and the result register.
//   when the receiver stalls the result holds, the back end waits, the queue
//   fills and full_o then stops further input.
// ----------------------------------------------------------------------------
module dda_line_pixel_stepper_top (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   push_i,
  output logic                                   full_o,
  input  logic                                   operation_i,
  input  logic signed [ddals_pkg::COORD_BITS-1:0] first_a_i,
  input  logic signed [ddals_pkg::COORD_BITS-1:0] first_b_i,
  input  logic signed [ddals_pkg::COORD_BITS-1:0] second_a_i,
  input  logic signed [ddals_pkg::COORD_BITS-1:0] second_b_i,
  input  logic        [15:0]                      line_color_i,
  output logic                                   empty_o,
  input  logic                                   pop_i,
  output logic signed [ddals_pkg::OUT_BITS-1:0]   main_h_o,
  output logic signed [ddals_pkg::OUT_BITS-1:0]   main_v_o,
  output logic signed [ddals_pkg::OUT_BITS-1:0]   side_h_o,
  output logic signed [ddals_pkg::OUT_BITS-1:0]   side_v_o,
  output logic        [15:0]                      pixel_color_o,
  output logic                                   last_column_o
);

  // classified item from the front, head of the queue for the back
  ddals_pkg::entry_t   front_entry, head_entry;
  logic                q_empty, q_pop;
  ddals_pkg::div_req_t div_req;
  ddals_pkg::div_rsp_t div_rsp;

  // front: axis choice, endpoint order and spans, all in the transfer cycle
  ddals_front u_front (
    .operation_i  (operation_i),
    .first_a_i    (first_a_i),
    .first_b_i    (first_b_i),
    .second_a_i   (second_a_i),
    .second_b_i   (second_b_i),
    .line_color_i (line_color_i),
    .entry_o      (front_entry)
  );

  // decoupling queue; its full flag is the input back-pressure
  ddals_queue u_queue (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_en_i   (push_i),
    .wr_data_i (front_entry),
    .full_o    (full_o),
    .rd_en_i   (q_pop),
    .rd_data_o (head_entry),
    .empty_o   (q_empty)
  );

  // gradient divider, only busy while a line loads
  ddals_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  // back: line state, column stepping and the result register
  ddals_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .q_empty_i     (q_empty),
    .q_data_i      (head_entry),
    .q_pop_o       (q_pop),
    .div_req_o     (div_req),
    .div_rsp_i     (div_rsp),
    .pop_i         (pop_i),
    .empty_o       (empty_o),
    .main_h_o      (main_h_o),
    .main_v_o      (main_v_o),
    .side_h_o      (side_h_o),
    .side_v_o      (side_v_o),
    .pixel_color_o (pixel_color_o),
    .last_column_o (last_column_o)
  );

endmodule

// File: rtl/ddals_front.sv
// ----------------------------------------------------------------------------
// ddals_front
// classifies an incoming item: major axis, endpoint order and span magnitudes
// ----------------------------------------------------------------------------
module ddals_front (
  input  logic                                   operation_i,
  input  logic signed [ddals_pkg::COORD_BITS-1:0] first_a_i,
  input  logic signed [ddals_pkg::COORD_BITS-1:0] first_b_i,
  input  logic signed [ddals_pkg::COORD_BITS-1:0] second_a_i,
  input  logic signed [ddals_pkg::COORD_BITS-1:0] second_b_i,
  input  logic        [15:0]                      line_color_i,
  output ddals_pkg::entry_t                       entry_o
);

  localparam int CB = ddals_pkg::COORD_BITS;

  logic signed [CB:0]   diff_a, diff_b, neg_a, neg_b;
  logic        [CB-1:0] mag_a, mag_b;
  logic signed [CB-1:0] maj_first, maj_second, min_first, min_second;
  logic                 steep, swap;

  always_comb begin
    diff_a = {second_a_i[CB-1], second_a_i} - {first_a_i[CB-1], first_a_i};
    diff_b = {second_b_i[CB-1], second_b_i} - {first_b_i[CB-1], first_b_i};
    neg_a  = -diff_a;
    neg_b  = -diff_b;
    mag_a  = diff_a[CB] ? neg_a[CB-1:0] : diff_a[CB-1:0];
    mag_b  = diff_b[CB] ? neg_b[CB-1:0] : diff_b[CB-1:0];
    steep  = mag_a > mag_b;

    maj_first  = steep ? first_a_i  : first_b_i;
    maj_second = steep ? second_a_i : second_b_i;
    min_first  = steep ? first_b_i  : first_a_i;
    min_second = steep ? second_b_i : second_a_i;
    swap       = maj_first > maj_second;

    entry_o.op       = ddals_pkg::op_e'(operation_i);
    entry_o.steep    = steep;
    entry_o.mj0      = swap ? maj_second : maj_first;
    entry_o.mj1      = swap ? maj_first  : maj_second;
    entry_o.mn0      = swap ? min_second : min_first;
    entry_o.dmaj     = steep ? mag_a : mag_b;
    entry_o.dmin_mag = steep ? mag_b : mag_a;
    // minor span changes sign when the endpoints trade places
    entry_o.dmin_neg = (steep ? diff_b[CB] : diff_a[CB]) ^ swap;
    entry_o.color    = line_color_i;
  end

endmodule

// File: rtl/ddals_queue.sv
// ----------------------------------------------------------------------------
// ddals_queue
// short first-in first-out queue between the front and the back
// ----------------------------------------------------------------------------
module ddals_queue (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              wr_en_i,
  input  ddals_pkg::entry_t wr_data_i,
  output logic              full_o,
  input  logic              rd_en_i,
  output ddals_pkg::entry_t rd_data_o,
  output logic              empty_o
);

  localparam int PB = ddals_pkg::PTR_BITS;

  ddals_pkg::entry_t mem_q [ddals_pkg::QUEUE_DEPTH];
  logic [PB-1:0]     wr_ptr_q, rd_ptr_q;
  logic [PB:0]       count_q;
  logic              do_wr, do_rd;

  assign full_o    = count_q == (PB+1)'(ddals_pkg::QUEUE_DEPTH);
  assign empty_o   = count_q == '0;
  assign do_wr     = wr_en_i && !full_o;
  assign do_rd     = rd_en_i && !empty_o;
  assign rd_data_o = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (do_wr) begin
      mem_q[wr_ptr_q] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr_q <= wr_ptr_q + PB'(1);
      end
      if (do_rd) begin
        rd_ptr_q <= rd_ptr_q + PB'(1);
      end
      if (do_wr && !do_rd) begin
        count_q <= count_q + (PB+1)'(1);
      end else if (do_rd && !do_wr) begin
        count_q <= count_q - (PB+1)'(1);
      end
    end
  end

endmodule

// File: rtl/ddals_div.sv
// ----------------------------------------------------------------------------
// ddals_div
// restoring divider for the gradient, one quotient bit per cycle
// ----------------------------------------------------------------------------
module ddals_div (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  ddals_pkg::div_req_t req_i,
  output ddals_pkg::div_rsp_t rsp_o
);

  localparam int CB = ddals_pkg::COORD_BITS;
  localparam int QB = ddals_pkg::QUOT_BITS;
  localparam int SB = ddals_pkg::SLOPE_BITS;
  localparam int NB = ddals_pkg::CNT_BITS;

  logic          busy_q, done_q, neg_q;
  logic [NB-1:0] cnt_q;
  logic [CB:0]   rem_q, trial, rem_next;
  logic [CB-1:0] div_q;
  logic [QB-1:0] quot_q;
  logic          ge;
  logic [SB-1:0] quot_ext;

  always_comb begin
    // first step tests the integer bit, later steps bring in a zero
    trial    = (cnt_q == '0) ? rem_q : {rem_q[CB-1:0], 1'b0};
    ge       = trial >= {1'b0, div_q};
    rem_next = ge ? trial - {1'b0, div_q} : trial;
    quot_ext = {{(SB-QB){1'b0}}, quot_q};
    rsp_o.done     = done_q;
    rsp_o.quotient = neg_q ? -quot_ext : quot_ext;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      neg_q  <= 1'b0;
      cnt_q  <= '0;
      rem_q  <= '0;
      div_q  <= '0;
      quot_q <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q <= 1'b1;
        neg_q  <= req_i.neg;
        cnt_q  <= '0;
        rem_q  <= {1'b0, req_i.dividend};
        div_q  <= req_i.divisor;
        quot_q <= '0;
      end else if (busy_q) begin
        rem_q  <= rem_next;
        quot_q <= {quot_q[QB-2:0], ge};
        cnt_q  <= cnt_q + NB'(1);
        if (cnt_q == NB'(ddals_pkg::FRAC_BITS)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

endmodule

// File: rtl/ddals_back.sv
// ----------------------------------------------------------------------------
// ddals_back
// line state, column stepping and the result register
// ----------------------------------------------------------------------------
module ddals_back (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   q_empty_i,
  input  ddals_pkg::entry_t                      q_data_i,
  output logic                                   q_pop_o,
  output ddals_pkg::div_req_t                    div_req_o,
  input  ddals_pkg::div_rsp_t                    div_rsp_i,
  input  logic                                   pop_i,
  output logic                                   empty_o,
  output logic signed [ddals_pkg::OUT_BITS-1:0]  main_h_o,
  output logic signed [ddals_pkg::OUT_BITS-1:0]  main_v_o,
  output logic signed [ddals_pkg::OUT_BITS-1:0]  side_h_o,
  output logic signed [ddals_pkg::OUT_BITS-1:0]  side_v_o,
  output logic        [15:0]                     pixel_color_o,
  output logic                                   last_column_o
);

  `include "dda_line_pixel_stepper_top_macros.svh"

  localparam int CB = ddals_pkg::COORD_BITS;
  localparam int OB = ddals_pkg::OUT_BITS;
  localparam int AB = ddals_pkg::ACC_BITS;
  localparam int FB = ddals_pkg::FRAC_BITS;
  localparam int SB = ddals_pkg::SLOPE_BITS;

  typedef enum logic {
    S_RUN,
    S_DIV
  } state_e;

  state_e               state_q;
  logic                 active_q, steep_q, out_valid_q;
  logic signed [OB-1:0] major_pos_q, major_end_q;
  logic signed [AB-1:0] accum_q;
  logic signed [SB-1:0] slope_q;
  logic        [15:0]   color_q;

  logic                 take_load, take_step, emit, slot_free, last;
  logic signed [OB-1:0] minor, minor_up;
  logic signed [AB-1:0] slope_ext;

  always_comb begin
    slot_free = !out_valid_q || pop_i;
    take_load = (state_q == S_RUN) && !q_empty_i && (q_data_i.op == ddals_pkg::OP_LOAD);
    take_step = (state_q == S_RUN) && !q_empty_i && (q_data_i.op == ddals_pkg::OP_STEP)
                && (!active_q || slot_free);
    // a step with no line in progress is dropped
    emit      = take_step && active_q;
    q_pop_o   = take_load || take_step;

    div_req_o.start    = take_load && (q_data_i.dmaj != '0);
    div_req_o.dividend = q_data_i.dmin_mag;
    div_req_o.divisor  = q_data_i.dmaj;
    div_req_o.neg      = q_data_i.dmin_neg;

    // truncate toward zero: floor, then bump negatives with a fraction
    minor     = accum_q[AB-1:FB]
              + OB'(accum_q[AB-1] && (accum_q[FB-1:0] != '0));
    minor_up  = minor + OB'(1);
    last      = major_pos_q >= major_end_q;
    slope_ext = {{(AB-SB){slope_q[SB-1]}}, slope_q};
  end

  assign empty_o = !out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= S_RUN;
      active_q      <= 1'b0;
      steep_q       <= 1'b0;
      out_valid_q   <= 1'b0;
      major_pos_q   <= '0;
      major_end_q   <= '0;
      accum_q       <= '0;
      slope_q       <= '0;
      color_q       <= '0;
      main_h_o      <= '0;
      main_v_o      <= '0;
      side_h_o      <= '0;
      side_v_o      <= '0;
      pixel_color_o <= '0;
      last_column_o <= 1'b0;
    end else begin
      unique case (state_q)
        S_RUN: begin
          if (take_load) begin
            steep_q     <= q_data_i.steep;
            major_pos_q <= {q_data_i.mj0[CB-1], q_data_i.mj0};
            major_end_q <= {q_data_i.mj1[CB-1], q_data_i.mj1};
            accum_q     <= {q_data_i.mn0[CB-1], q_data_i.mn0, {FB{1'b0}}};
            color_q     <= q_data_i.color;
            if (q_data_i.dmaj == '0) begin
              slope_q  <= ddals_pkg::SLOPE_ONE;
              active_q <= 1'b1;
            end else begin
              active_q <= 1'b0;
              state_q  <= S_DIV;
            end
          end else if (emit) begin
            if (last) begin
              active_q <= 1'b0;
            end else begin
              major_pos_q <= major_pos_q + OB'(1);
              accum_q     <= accum_q + slope_ext;
            end
          end
        end
        S_DIV: begin
          if (div_rsp_i.done) begin
            slope_q  <= div_rsp_i.quotient;
            active_q <= 1'b1;
            state_q  <= S_RUN;
          end
        end
        default: begin
          state_q <= S_RUN;
        end
      endcase

      if (emit) begin
        out_valid_q   <= 1'b1;
        main_h_o      <= steep_q ? minor       : major_pos_q;
        main_v_o      <= steep_q ? major_pos_q : minor;
        side_h_o      <= steep_q ? minor_up    : major_pos_q;
        side_v_o      <= steep_q ? major_pos_q : minor_up;
        pixel_color_o <= color_q;
        last_column_o <= last;
      end else if (pop_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  `DDALS_ASSERT_NOW(a_div_start_in_run, div_req_o.start, state_q == S_RUN, "divide started mid-load")
  `DDALS_ASSERT_NOW(a_no_pop_in_div, state_q == S_DIV, !q_pop_o, "queue popped during divide")
  `DDALS_ASSERT_NOW(a_done_in_div, div_rsp_i.done, state_q == S_DIV, "stray divider completion")
  `DDALS_ASSERT_NOW(a_emit_has_room, emit, slot_free, "result register overwritten")
  `DDALS_ASSERT_NEXT(a_last_ends_line, emit && last, !active_q, "line still active after last")

endmodule
